### hw/rtl/ffdi_pkg.sv
`default_nettype none
package ffdi_pkg;

	// register indexes
	localparam logic [7:0] REG_REST_LEVEL     = 8'd0;
	localparam logic [7:0] REG_REST_TOLERANCE = 8'd1;
	localparam logic [7:0] REG_LAND_THRESHOLD = 8'd2;
	localparam logic [7:0] REG_GRAVITY        = 8'd3;

	// register reset values
	localparam logic [15:0] REST_LEVEL_RST     = 16'd4096;
	localparam logic [15:0] REST_TOLERANCE_RST = 16'd410;
	localparam logic [15:0] LAND_THRESHOLD_RST = 16'd6144;
	localparam logic [31:0] GRAVITY_RST        = 32'd642253;

	// phase codes
	localparam logic [1:0] PH_WAIT   = 2'd0;
	localparam logic [1:0] PH_FALL   = 2'd1;
	localparam logic [1:0] PH_LANDED = 2'd2;

	// divisors of the three scaled products
	localparam logic [21:0] DIV_VEL   = 22'd4096000;
	localparam logic [21:0] DIV_DIST  = 22'd1000;
	localparam logic [21:0] DIV_IDEAL = 22'd2000000;

	// step counts of the serial units (setup cycle is count zero)
	localparam logic [5:0] MUL_LAST  = 6'd32;
	localparam logic [5:0] SQRT_LAST = 6'd16;
	localparam logic [5:0] DIV_LAST  = 6'd33;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQZ,
		ST_SQRT,
		ST_ROUND,
		ST_CHECK,
		ST_VM1,
		ST_VM2,
		ST_VDIV,
		ST_DM,
		ST_DDIV,
		ST_LM1,
		ST_LM2,
		ST_LDIV,
		ST_DONE
	} state_t;

	// add a clamped step to a signed accumulator, saturate to 32 bits
	function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic neg,
			input logic [32:0] q);
		logic signed [33:0] r;
		r = neg ? ($signed({{2{acc[31]}}, acc}) - $signed({1'b0, q}))
		        : ($signed({{2{acc[31]}}, acc}) + $signed({1'b0, q}));
		if (r > 34'sd2147483647)
			sat_add = 32'h7fff_ffff;
		else if (r < -34'sd2147483648)
			sat_add = 32'h8000_0000;
		else
			sat_add = r[31:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/free_fall_detector_integrator_top.sv
// Free-fall detector and integrator.
// Input stream (s_*): one word per accelerometer sample, timestamp and three
// signed Q3.12 axes. Output stream (m_*): one word per sample with phase,
// magnitude, velocity and distance accumulators, fall time, ideal distance,
// and a just-landed flag in tuser. Config channel (cfg_*): always ready,
// register index and data; write only while no sample is in flight.
// Each sample runs through a shared shift-add multiplier (one multiplier bit
// per cycle), a bit-pair square root (two radicand bits per cycle) and a
// restoring divider (one quotient bit per cycle), driven by one sequencer.
// While waiting or landed a sample runs the squares, root and check; while
// falling it also runs the velocity and distance products and divisions,
// and the landing sample adds the ideal-distance product and division. One
// sample is in work at a time; the next sample can be accepted in the cycle
// after the result is loaded into the output register.
// Reset clears phase, accumulators and times, and loads register defaults.
// When the receiver stalls, the result word holds in the output register;
// the next sample may be accepted and computed, then waits to be loaded.
`default_nettype none
module free_fall_detector_integrator_top import ffdi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [31:0] time_ms, [47:32] accel_x, [63:48] accel_y, [79:64] accel_z
	input  wire logic [79:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [1:0] phase, [17:2] magnitude, [49:18] velocity,
	// [81:50] compensated_distance, [113:82] fall_time_ms,
	// [145:114] ideal_distance, [151:146] zero
	output logic [151:0]      m_tdata,
	// [0] just_landed
	output logic [0:0]        m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	state_t state_q, state_nx;

	logic [15:0] rest_q, tol_q, thr_q;
	logic [31:0] grav_q;

	logic [1:0]  phase_q;
	logic [31:0] fst_q, prev_q, vel_q, dist_q, ltime_q, lideal_q;

	logic [31:0] t_q;
	logic [16:0] ax_q, ay_q, az_q;
	logic [31:0] sum_q;
	logic [95:0] acc_q;
	logic [63:0] mcand_q;
	logic [31:0] mplier_q;
	logic [5:0]  cnt_q;
	logic [31:0] root_q, rem_q, bit_q;
	logic [15:0] mag_q;
	logic [31:0] dt_q, ft_q;
	logic [15:0] ad_q;
	logic        vneg_q, jl_q, ovf_q;
	logic [21:0] drem_q;
	logic [31:0] dlow_q, quot_q;

	logic        out_valid_q;
	logic [151:0] out_data_q;
	logic        out_user_q;

	logic [21:0] divisor;
	logic [22:0] trial;
	logic [32:0] q_full;
	logic [31:0] rb;
	logic [16:0] dmag, dabs, drest;
	logic [31:0] vabs;
	logic        in_acc, load_out;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;
	assign in_acc    = s_tvalid && s_tready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// select divisor, form the divider's trial and clamped quotient, the root trial and the rest differences
	always_comb begin
		case (state_q)
			ST_VDIV: divisor = DIV_VEL;
			ST_DDIV: divisor = DIV_DIST;
			default: divisor = DIV_IDEAL;
		endcase
		trial  = {drem_q, dlow_q[31]};
		q_full = ovf_q ? 33'h1_0000_0000 : {1'b0, quot_q};
		rb     = root_q + bit_q;
		dmag   = {1'b0, mag_q} - {1'b0, rest_q};
		dabs   = dmag[16] ? (17'd0 - dmag) : dmag;
		drest  = {1'b0, rest_q} - {1'b0, mag_q};
		vabs   = vel_q[31] ? (32'd0 - vel_q) : vel_q;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_nx = ST_SQX;
			ST_SQX:   if (cnt_q == MUL_LAST) state_nx = ST_SQY;
			ST_SQY:   if (cnt_q == MUL_LAST) state_nx = ST_SQZ;
			ST_SQZ:   if (cnt_q == MUL_LAST) state_nx = ST_SQRT;
			ST_SQRT:  if (cnt_q == SQRT_LAST) state_nx = ST_ROUND;
			ST_ROUND: state_nx = ST_CHECK;
			ST_CHECK: begin
				if (phase_q == PH_FALL)
					state_nx = ST_VM1;
				else if (phase_q == PH_WAIT && !(dabs < {1'b0, tol_q}) && mag_q >= thr_q)
					state_nx = ST_LM1;
				else
					state_nx = ST_DONE;
			end
			ST_VM1:   if (cnt_q == MUL_LAST) state_nx = ST_VM2;
			ST_VM2:   if (cnt_q == MUL_LAST) state_nx = ST_VDIV;
			ST_VDIV:  if (cnt_q == DIV_LAST) state_nx = ST_DM;
			ST_DM:    if (cnt_q == MUL_LAST) state_nx = ST_DDIV;
			ST_DDIV:  if (cnt_q == DIV_LAST) state_nx = (mag_q >= thr_q) ? ST_LM1 : ST_DONE;
			ST_LM1:   if (cnt_q == MUL_LAST) state_nx = ST_LM2;
			ST_LM2:   if (cnt_q == MUL_LAST) state_nx = ST_LDIV;
			ST_LDIV:  if (cnt_q == DIV_LAST) state_nx = ST_DONE;
			ST_DONE:  if (load_out) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// control state and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 6'd0;
			out_valid_q <= 1'b0;
			rest_q      <= REST_LEVEL_RST;
			tol_q       <= REST_TOLERANCE_RST;
			thr_q       <= LAND_THRESHOLD_RST;
			grav_q      <= GRAVITY_RST;
			phase_q     <= PH_WAIT;
			fst_q       <= 32'd0;
			prev_q      <= 32'd0;
			vel_q       <= 32'd0;
			dist_q      <= 32'd0;
			ltime_q     <= 32'd0;
			lideal_q    <= 32'd0;
			jl_q        <= 1'b0;
		end else begin
			state_q <= state_nx;
			// advance the step counter, restart on every state change
			cnt_q <= (state_nx != state_q) ? 6'd0 : cnt_q + 6'd1;

			// take config words
			if (cfg_valid) begin
				case (cfg_index)
					REG_REST_LEVEL:     rest_q <= cfg_data[15:0];
					REG_REST_TOLERANCE: tol_q  <= cfg_data[15:0];
					REG_LAND_THRESHOLD: thr_q  <= cfg_data[15:0];
					REG_GRAVITY:        grav_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_acc) jl_q <= 1'b0;

			// set valid on load, drop the output word once taken
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_CHECK: begin
					if (phase_q == PH_WAIT && !(dabs < {1'b0, tol_q})) begin
						fst_q   <= t_q;
						prev_q  <= t_q;
						phase_q <= PH_FALL;
						if (mag_q >= thr_q) jl_q <= 1'b1;
					end
				end
				ST_VDIV: if (cnt_q == DIV_LAST) vel_q <= sat_add(vel_q, vneg_q, q_full);
				ST_DDIV: begin
					if (cnt_q == DIV_LAST) begin
						dist_q <= sat_add(dist_q, vel_q[31], q_full);
						prev_q <= t_q;
						if (mag_q >= thr_q) jl_q <= 1'b1;
					end
				end
				ST_LDIV: begin
					if (cnt_q == DIV_LAST) begin
						ltime_q  <= ft_q;
						lideal_q <= q_full[32] ? 32'hffff_ffff : q_full[31:0];
						phase_q  <= PH_LANDED;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: capture, serial multiplier, root and divider
	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_q  <= s_tdata[31:0];
			ax_q <= s_tdata[47] ? (17'd0 - {1'b1, s_tdata[47:32]}) : {1'b0, s_tdata[47:32]};
			ay_q <= s_tdata[63] ? (17'd0 - {1'b1, s_tdata[63:48]}) : {1'b0, s_tdata[63:48]};
			az_q <= s_tdata[79] ? (17'd0 - {1'b1, s_tdata[79:64]}) : {1'b0, s_tdata[79:64]};
		end

		case (state_q)
			ST_SQX, ST_SQY, ST_SQZ, ST_VM1, ST_VM2, ST_DM, ST_LM1, ST_LM2: begin
				if (cnt_q == 6'd0) begin
					// load operands for this product
					acc_q <= 96'd0;
					case (state_q)
						ST_SQX: begin
							mcand_q  <= {47'd0, ax_q};
							mplier_q <= {15'd0, ax_q};
						end
						ST_SQY: begin
							sum_q    <= acc_q[31:0];
							mcand_q  <= {47'd0, ay_q};
							mplier_q <= {15'd0, ay_q};
						end
						ST_SQZ: begin
							sum_q    <= sum_q + acc_q[31:0];
							mcand_q  <= {47'd0, az_q};
							mplier_q <= {15'd0, az_q};
						end
						ST_VM1: begin
							mcand_q  <= {32'd0, grav_q};
							mplier_q <= {16'd0, ad_q};
						end
						ST_VM2: begin
							mcand_q  <= acc_q[63:0];
							mplier_q <= dt_q;
						end
						ST_DM: begin
							mcand_q  <= {32'd0, vabs};
							mplier_q <= dt_q;
						end
						ST_LM1: begin
							mcand_q  <= {32'd0, ft_q};
							mplier_q <= ft_q;
						end
						default: begin
							mcand_q  <= acc_q[63:0];
							mplier_q <= grav_q;
						end
					endcase
				end else begin
					// shift-add one multiplier bit, MSB first
					acc_q    <= {acc_q[94:0], 1'b0} + (mplier_q[31] ? {32'd0, mcand_q} : 96'd0);
					mplier_q <= {mplier_q[30:0], 1'b0};
				end
			end
			ST_SQRT: begin
				if (cnt_q == 6'd0) begin
					rem_q  <= sum_q + acc_q[31:0];
					root_q <= 32'd0;
					bit_q  <= 32'h4000_0000;
				end else begin
					// resolve two radicand bits
					if (rem_q >= rb) begin
						rem_q  <= rem_q - rb;
						root_q <= {1'b0, root_q[31:1]} + bit_q;
					end else begin
						root_q <= {1'b0, root_q[31:1]};
					end
					bit_q <= {2'b00, bit_q[31:2]};
				end
			end
			ST_ROUND: mag_q <= (rem_q > root_q) ? (root_q[15:0] + 16'd1) : root_q[15:0];
			ST_CHECK: begin
				dt_q   <= t_q - prev_q;
				vneg_q <= drest[16];
				ad_q   <= drest[16] ? (16'd0 - drest[15:0]) : drest[15:0];
				ft_q   <= 32'd0;
			end
			ST_VDIV, ST_DDIV, ST_LDIV: begin
				if (cnt_q == 6'd0) begin
					ovf_q  <= acc_q[95:32] >= {42'd0, divisor};
					drem_q <= acc_q[53:32];
					dlow_q <= acc_q[31:0];
					quot_q <= 32'd0;
				end else if (cnt_q != DIV_LAST) begin
					// restoring step, one quotient bit
					if (trial >= {1'b0, divisor}) begin
						drem_q <= 22'(trial - {1'b0, divisor});
						quot_q <= {quot_q[30:0], 1'b1};
					end else begin
						drem_q <= trial[21:0];
						quot_q <= {quot_q[30:0], 1'b0};
					end
					dlow_q <= {dlow_q[30:0], 1'b0};
				end else if (state_q == ST_DDIV) begin
					ft_q <= t_q - fst_q;
				end
			end
			default: ;
		endcase

		// hold the result word in the output register
		if (load_out) begin
			out_data_q <= {6'd0, lideal_q, ltime_q, dist_q, vel_q, mag_q, phase_q};
			out_user_q <= jl_q;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/ffdi_chk.sv
`default_nettype none
module ffdi_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [151:0] m_tdata,
	input wire logic [0:0]   m_tuser
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed under stall");

	// one sample in work: no accept right after an accept
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second sample accepted while busy");

	// phase code stays in range
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("bad phase code");

	// landing flag only with landed phase
	a_land: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[1:0] == 2'd2)
		else $error("landing flag without landed phase");

endmodule

bind free_fall_detector_integrator_top ffdi_chk u_ffdi_chk (.*);
`default_nettype wire

### test/ffdi_checker.sv
`timescale 1ns / 1ps
module ffdi_checker import ffdi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [79:0]  s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [151:0] m_tdata,
	input  wire logic [0:0]   m_tuser,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output int                mismatches,
	output int                outstanding
);

	typedef struct packed {
		logic [1:0]  phase;
		logic [15:0] magnitude;
		logic [31:0] velocity;
		logic [31:0] distance;
		logic [31:0] fall_time;
		logic [31:0] ideal;
		logic        just_landed;
	} fall_report_t;

	localparam logic [63:0] STEP_CLAMP = 64'h1_0000_0000;

	fall_report_t pending_reports[$];

	// register shadows
	logic [15:0] rest_level, rest_tol, land_thr;
	logic [31:0] gravity;

	// detector state shadows
	logic [1:0]         cur_phase;
	logic [31:0]        fall_start, last_time, land_time, land_ideal;
	logic signed [31:0] vel_acc, dist_acc;

	// rounded square root of the sum of squares
	function automatic logic [15:0] accel_magnitude(input logic [79:0] word);
		logic signed [31:0] x, y, z;
		logic [63:0] s, root, bitv, rem;
		x = $signed(word[47:32]);
		y = $signed(word[63:48]);
		z = $signed(word[79:64]);
		s = 64'(x * x) + 64'(y * y) + 64'(z * z);
		root = 0;
		rem = s;
		bitv = 64'd1 << 30;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		if (s - root * root > root)
			root = root + 1;
		return root[15:0];
	endfunction

	// scaled product, clamped to one past 32 bits on overflow
	function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] div);
		if (a == 0 || b == 0)
			return 0;
		if (a > 64'hFFFF_FFFF_FFFF_FFFF / b)
			return STEP_CLAMP;
		return (a * b) / div;
	endfunction

	function automatic logic signed [31:0] saturate_step(input logic signed [31:0] acc,
			input logic neg, input logic [63:0] q);
		longint r;
		if (q > STEP_CLAMP)
			q = STEP_CLAMP;
		r = neg ? longint'(acc) - longint'(q) : longint'(acc) + longint'(q);
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// integrate velocity, then distance over one time step
	task automatic integrate_fall(input logic [15:0] mag, input logic [31:0] t);
		logic [31:0] dt;
		int diff;
		logic neg;
		logic [63:0] ad, q, av;
		dt = t - last_time;
		diff = int'(rest_level) - int'(mag);
		neg = diff < 0;
		ad = neg ? 64'(-diff) : 64'(diff);
		q = scaled_product(64'(gravity) * ad, 64'(dt), 64'(DIV_VEL));
		vel_acc = saturate_step(vel_acc, neg, q);
		neg = vel_acc < 0;
		av = neg ? 64'(-longint'(vel_acc)) : 64'(longint'(vel_acc));
		q = scaled_product(av, 64'(dt), 64'(DIV_DIST));
		dist_acc = saturate_step(dist_acc, neg, q);
		last_time = t;
	endtask

	task automatic touch_down(input logic [31:0] t);
		logic [63:0] ft, p;
		ft = 64'(t - fall_start);
		p = scaled_product(64'(gravity), ft * ft, 64'(DIV_IDEAL));
		land_time = ft[31:0];
		land_ideal = p > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : p[31:0];
		cur_phase = PH_LANDED;
	endtask

	function automatic fall_report_t unpack_report();
		fall_report_t r;
		r.phase = m_tdata[1:0];
		r.magnitude = m_tdata[17:2];
		r.velocity = m_tdata[49:18];
		r.distance = m_tdata[81:50];
		r.fall_time = m_tdata[113:82];
		r.ideal = m_tdata[145:114];
		r.just_landed = m_tuser[0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fall_report_t want, got;
		logic [15:0] mag;
		logic [31:0] t;
		logic landed_now;
		int d;
		if (!arst_n) begin
			rest_level = REST_LEVEL_RST;
			rest_tol = REST_TOLERANCE_RST;
			land_thr = LAND_THRESHOLD_RST;
			gravity = GRAVITY_RST;
			cur_phase = PH_WAIT;
			fall_start = 0;
			last_time = 0;
			vel_acc = 0;
			dist_acc = 0;
			land_time = 0;
			land_ideal = 0;
			mismatches = 0;
			pending_reports.delete();
		end else begin
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_REST_LEVEL:     rest_level = cfg_data[15:0];
					REG_REST_TOLERANCE: rest_tol = cfg_data[15:0];
					REG_LAND_THRESHOLD: land_thr = cfg_data[15:0];
					REG_GRAVITY:        gravity = cfg_data;
					default: ;
				endcase
			end

			// predict the result for each accepted sample word
			if (s_tvalid && s_tready) begin
				t = s_tdata[31:0];
				mag = accel_magnitude(s_tdata);
				landed_now = 1'b0;
				if (cur_phase == PH_WAIT) begin
					d = int'(mag) - int'(rest_level);
					if (d < 0)
						d = -d;
					if (!(d < int'(rest_tol))) begin
						fall_start = t;
						last_time = t;
						cur_phase = PH_FALL;
						if (mag >= land_thr) begin
							touch_down(t);
							landed_now = 1'b1;
						end
					end
				end else if (cur_phase == PH_FALL) begin
					integrate_fall(mag, t);
					if (mag >= land_thr) begin
						touch_down(t);
						landed_now = 1'b1;
					end
				end
				want = '{cur_phase, mag, vel_acc, dist_acc, land_time, land_ideal, landed_now};
				pending_reports.push_back(want);
			end

			// compare each result word with the oldest prediction
			if (m_tvalid && m_tready) begin
				got = unpack_report();
				if (pending_reports.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result word %h", got);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("mismatch phase exp %0d got %0d, mag exp %0d got %0d",
								want.phase, got.phase, want.magnitude, got.magnitude);
							$display("  vel exp %h got %h, dist exp %h got %h",
								want.velocity, got.velocity, want.distance, got.distance);
							$display("  time exp %h got %h, ideal exp %h got %h, jl %b/%b",
								want.fall_time, got.fall_time, want.ideal, got.ideal,
								want.just_landed, got.just_landed);
						end
						mismatches++;
					end
				end
			end
		end
		outstanding = pending_reports.size();
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ffdi_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// [31:0] time_ms, [47:32] accel_x, [63:48] accel_y, [79:64] accel_z
	logic [79:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [1:0] phase, [17:2] magnitude, [49:18] velocity, [81:50] distance,
	// [113:82] fall_time_ms, [145:114] ideal_distance, [151:146] zero
	logic [151:0] m_tdata;
	// [0] just_landed
	logic [0:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	int mismatches, outstanding;
	int cycles = 0;
	int samples_sent = 0;
	logic hold_rx = 1'b0;
	logic [31:0] now_ms = 32'd1000;

	free_fall_detector_integrator_top u_dut (.*);

	ffdi_checker u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls per word, plus the long hold when asked
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			if (gap > 0 || hold_rx) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rx) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// long receiver hold while samples keep coming
	initial begin
		wait (samples_sent >= 300);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_rx <= 1'b0;
	end

	task automatic send_sample(input logic [31:0] t, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x, t};
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	// drop valid and wait for every result word
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_axis();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 12287)) - 16'd6144;
	endfunction

	// next timestamp: mostly short steps, sometimes a jump or a repeat
	function automatic logic [31:0] next_time(input logic [31:0] t);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			return $urandom;
		if (pick < 6)
			return t;
		return t + $urandom_range(1, 20);
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// at rest with defaults: stay inside the tolerance band
		send_sample(now_ms, 16'd0, 16'd0, 16'd4096);
		send_sample(now_ms + 1, 16'd0, 16'd4505, 16'd0);
		send_sample(now_ms + 2, 16'd0, 16'd0, 16'hF001);
		send_sample(now_ms + 3, 16'd2048, 16'd2048, 16'd2896);
		drain();

		// wide band, top threshold: nothing can leave waiting
		write_reg(REG_REST_LEVEL, 32'd0);
		write_reg(REG_REST_TOLERANCE, 32'hFFFF);
		write_reg(REG_LAND_THRESHOLD, 32'hFFFF);
		write_reg(REG_GRAVITY + 8'd1 + 8'($urandom_range(0, 251)), $urandom);
		send_sample(32'd0, 16'h8000, 16'h8000, 16'h8000);
		send_sample(32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(32'd0, 16'd0, 16'd0, 16'd0);
		send_sample(32'h8000_0000, 16'h8000, 16'h7FFF, 16'd1);
		send_sample(32'h7FFF_FFFF, 16'hFFFF, 16'd0, 16'h8000);
		for (int i = 0; i < 150; i++)
			send_sample($urandom, 16'($urandom), 16'($urandom), 16'($urandom));
		drain();

		// zero tolerance: the next sample starts a fall; threshold stays out of reach
		write_reg(REG_REST_LEVEL, 32'd4096);
		write_reg(REG_REST_TOLERANCE, 32'd0);
		write_reg(REG_GRAVITY, GRAVITY_RST);
		send_sample(now_ms, 16'd0, 16'd0, 16'd0);
		send_sample(now_ms + 5, 16'd0, 16'd0, 16'd100);
		send_sample(now_ms + 5, 16'd0, 16'd0, 16'd4096);
		send_sample(now_ms + 30, 16'h8000, 16'h8000, 16'h8000);
		now_ms = now_ms + 30;
		drain();

		// falling runs under several register settings
		for (int blk = 0; blk < 6; blk++) begin
			case (blk)
				0: write_reg(REG_GRAVITY, 32'd0);
				1: write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
				2: write_reg(REG_REST_LEVEL, 32'hFFFF);
				3: write_reg(REG_REST_LEVEL, 32'd0);
				default: begin
					write_reg(REG_REST_LEVEL, $urandom_range(3000, 5000));
					write_reg(REG_GRAVITY, $urandom_range(100000, 1000000));
					write_reg(REG_REST_TOLERANCE, $urandom);
				end
			endcase
			for (int i = 0; i < 125; i++) begin
				now_ms = next_time(now_ms);
				send_sample(now_ms, rand_axis(), rand_axis(), rand_axis());
			end
			drain();
		end

		// drop the threshold: the next sample integrates and lands
		write_reg(REG_REST_LEVEL, REST_LEVEL_RST);
		write_reg(REG_GRAVITY, GRAVITY_RST);
		write_reg(REG_LAND_THRESHOLD, 32'd0);
		send_sample(now_ms + 7, 16'd0, 16'd0, 16'd0);
		for (int i = 0; i < 30; i++)
			send_sample($urandom, 16'($urandom), 16'($urandom), 16'($urandom));
		drain();
		repeat (400) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
